FILE: src/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the most frequent byte finder.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int SYM_W   = 8;
  localparam int SYM_N   = 1 << SYM_W;
  localparam int CNT_W   = 11;
  localparam int MAX_TEXT = 1024;

  // saturation point of a per-symbol count
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT);

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } sym_word_t;

  typedef struct packed {
    logic [7:0]  mode_symbol;
    logic [10:0] mode_count;
  } mode_word_t;

  // one histogram entry: count and rank of first appearance
  typedef struct packed {
    cnt_t cnt;
    sym_t rank;
  } entry_t;

  // updated entry handed from the histogram stage to the best tracker
  typedef struct packed {
    logic valid;
    logic last;
    sym_t sym;
    cnt_t cnt;
    sym_t rank;
  } upd_t;

endpackage

FILE: src/most_frequent_byte_finder.sv
// ----------------------------------------------------------------------------
// most_frequent_byte_finder
// Byte histogram mode: counts each byte value of a text and reports the
// most frequent one (earliest first appearance on ties) on the last byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | word
//  sym     | in  | sym_valid / sym_stall   | symbol, last_symbol
//  mode    | out | mode_valid / mode_stall | mode_symbol, mode_count
//
// One byte per cycle while sym_stall is low; a word is read from the count
// RAM on acceptance and written back when the s1 stage commits, the last
// write forwarded around the RAM. A result is registered when its last byte
// commits. Reset clears the valid bits at once; no clearing pass. The
// stores also clear when each last byte commits.
// sym_stall rises only when a last byte waits behind an untaken result.
// ----------------------------------------------------------------------------
module most_frequent_byte_finder (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_stall,
  input  mfb_pkg::sym_word_t  sym_data,
  output logic                mode_valid,
  input  logic                mode_stall,
  output mfb_pkg::mode_word_t mode_data
);
  import mfb_pkg::*;

  upd_t upd;
  logic take;

  mfb_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .take      (take),
    .upd       (upd)
  );

  mfb_best u_best (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .take       (take),
    .mode_valid (mode_valid),
    .mode_stall (mode_stall),
    .mode_data  (mode_data)
  );

endmodule

FILE: src/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/mfb_hist.sv
// ----------------------------------------------------------------------------
// mfb_hist
// Histogram store: read-modify-write of the count/rank RAM, one symbol per
// cycle unless a last symbol is held, with per-entry valid bits for the
// clear and forwarding of the most recent write.
// ----------------------------------------------------------------------------
module mfb_hist (
  input  logic               clk,
  input  logic               rst,
  input  logic               sym_valid,
  output logic               sym_stall,
  input  mfb_pkg::sym_word_t sym_data,
  input  logic               take,
  output mfb_pkg::upd_t      upd
);
  import mfb_pkg::*;

  logic       s1_valid;
  sym_word_t  s1_word;
  logic [SYM_N-1:0] seen;
  sym_t       distinct;
  sym_t       fwd_sym;
  entry_t     fwd_entry;
  entry_t     rd_entry;
  entry_t     old_entry;
  entry_t     new_entry;
  logic       adv;
  logic       accept;
  logic       commit;
  logic       is_new;

  // only a last word waiting for a full, stalled output register holds the stage
  assign adv       = !s1_valid || !s1_word.last_symbol || take;
  assign sym_stall = !adv;
  assign accept    = sym_valid && adv;
  assign commit    = s1_valid && adv;

  mfb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SYM_N)
  ) u_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (s1_word.symbol),
    .wdata (new_entry),
    .re    (accept),
    .raddr (sym_data.symbol),
    .rdata (rd_entry)
  );

  always_comb begin
    is_new = !seen[s1_word.symbol];
    if (is_new) begin
      old_entry = '0;
    end else if (fwd_sym == s1_word.symbol) begin
      // RAM read may have raced the previous write to this entry
      old_entry = fwd_entry;
    end else begin
      old_entry = rd_entry;
    end
    new_entry.cnt  = (old_entry.cnt == MAX_CNT) ? old_entry.cnt : old_entry.cnt + 1'b1;
    new_entry.rank = is_new ? distinct : old_entry.rank;
  end

  always_comb begin
    upd.valid = commit;
    upd.last  = s1_word.last_symbol;
    upd.sym   = s1_word.symbol;
    upd.cnt   = new_entry.cnt;
    upd.rank  = new_entry.rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sym_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= sym_data;
    end
    if (commit) begin
      fwd_sym   <= s1_word.symbol;
      fwd_entry <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      distinct <= '0;
    end else if (commit) begin
      if (s1_word.last_symbol) begin
        seen     <= '0;
        distinct <= '0;
      end else begin
        seen[s1_word.symbol] <= 1'b1;
        if (is_new) begin
          distinct <= distinct + 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/mfb_best.sv
// ----------------------------------------------------------------------------
// mfb_best
// Running best tracker and result register.
// ----------------------------------------------------------------------------
module mfb_best (
  input  logic                clk,
  input  logic                rst,
  input  mfb_pkg::upd_t       upd,
  output logic                take,
  output logic                mode_valid,
  input  logic                mode_stall,
  output mfb_pkg::mode_word_t mode_data
);
  import mfb_pkg::*;

  sym_t best_symbol;
  cnt_t best_count;
  sym_t best_rank;
  sym_t best_symbol_next;
  cnt_t best_count_next;
  sym_t best_rank_next;
  logic lead;

  assign take = !mode_valid || !mode_stall;

  // ties go to the earlier first appearance
  assign lead = (upd.cnt > best_count) ||
                ((upd.cnt == best_count) && (upd.rank < best_rank));

  always_comb begin
    if (lead) begin
      best_symbol_next = upd.sym;
      best_count_next  = upd.cnt;
      best_rank_next   = upd.rank;
    end else begin
      best_symbol_next = best_symbol;
      best_count_next  = best_count;
      best_rank_next   = best_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_symbol <= '0;
      best_count  <= '0;
      best_rank   <= '0;
    end else if (upd.valid) begin
      if (upd.last) begin
        best_symbol <= '0;
        best_count  <= '0;
        best_rank   <= '0;
      end else begin
        best_symbol <= best_symbol_next;
        best_count  <= best_count_next;
        best_rank   <= best_rank_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_valid <= 1'b0;
    end else if (upd.valid && upd.last) begin
      mode_valid <= 1'b1;
    end else if (!mode_stall) begin
      mode_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.valid && upd.last) begin
      mode_data.mode_symbol <= best_symbol_next;
      mode_data.mode_count  <= best_count_next;
    end
  end

endmodule

FILE: src/mfb_checker.sv
// ----------------------------------------------------------------------------
// mfb_checker
// Port-level checks for most_frequent_byte_finder, bound to the top level.
// ----------------------------------------------------------------------------
module mfb_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  input  logic                sym_stall,
  input  mfb_pkg::sym_word_t  sym_data,
  input  logic                mode_valid,
  input  logic                mode_stall,
  input  mfb_pkg::mode_word_t mode_data
);
  import mfb_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    sym_valid && sym_stall |=> sym_valid && $stable(sym_data))
    else $error("input word dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    mode_valid && mode_stall |=> mode_valid && $stable(mode_data))
    else $error("result word dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sym_stall |-> mode_valid && mode_stall)
    else $error("input stalled without a stalled result");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    mode_valid |-> mode_data.mode_count != '0)
    else $error("result with zero count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !mode_valid)
    else $error("result present after reset");

endmodule

bind most_frequent_byte_finder mfb_checker u_mfb_checker (
  .clk        (clk),
  .rst        (rst),
  .sym_valid  (sym_valid),
  .sym_stall  (sym_stall),
  .sym_data   (sym_data),
  .mode_valid (mode_valid),
  .mode_stall (mode_stall),
  .mode_data  (mode_data)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for most_frequent_byte_finder: directed texts, a
// saturation text, an all-values text, then random texts. Every mode word
// is checked against a local byte histogram model or a typed expected word,
// with random idling on both channels until the last random texts.
// ----------------------------------------------------------------------------
module tb;
  import mfb_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sym_valid = 1'b0;
  logic       sym_stall;
  sym_word_t  sym_data = '0;
  logic       mode_valid;
  logic       mode_stall = 1'b0;
  mode_word_t mode_data;

  most_frequent_byte_finder u_dut (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .mode_valid(mode_valid),
    .mode_stall(mode_stall),
    .mode_data (mode_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // histogram model state
  cnt_t       hist_count [SYM_N];
  sym_t       hist_rank  [SYM_N];
  logic [8:0] distinct_n;
  sym_t       lead_sym;
  cnt_t       lead_cnt;
  sym_t       lead_rank;

  mode_word_t pending_modes [$];
  int         mismatches = 0;
  bit         quiet = 1'b0;

  function automatic void clear_tally();
    for (int i = 0; i < SYM_N; i++) begin
      hist_count[i] = '0;
      hist_rank[i]  = '0;
    end
    distinct_n = '0;
    lead_sym   = '0;
    lead_cnt   = '0;
    lead_rank  = '0;
  endfunction

  // returns 1 when the byte closes a text, with the mode word in res
  function automatic bit tally_byte(input sym_t s, input bit last, output mode_word_t res);
    cnt_t c;
    sym_t r;
    res = '0;
    c = hist_count[s];
    if (c == '0) begin
      hist_rank[s] = distinct_n[7:0];
      distinct_n   = distinct_n + 9'd1;
    end
    if (c < MAX_CNT) c = c + 1'b1;
    hist_count[s] = c;
    r = hist_rank[s];
    // ties go to the earlier first appearance
    if (c > lead_cnt || (c == lead_cnt && r < lead_rank)) begin
      lead_sym  = s;
      lead_cnt  = c;
      lead_rank = r;
    end
    if (last) begin
      res.mode_symbol = lead_sym;
      res.mode_count  = lead_cnt;
      clear_tally();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // sends one word; typed_exp replaces the model's word when use_typed is set
  task automatic send_byte(input sym_t s, input bit last, input bit use_typed,
                           input mode_word_t typed_exp);
    int         gap;
    mode_word_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      sym_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sym_data.symbol      = s;
    sym_data.last_symbol = last;
    sym_valid = 1'b1;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
    if (tally_byte(s, last, res)) begin
      pending_modes = {pending_modes, use_typed ? typed_exp : res};
    end
    @(negedge clk);
  endtask

  // receiver stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (!quiet && stall_left > 0) begin
        mode_stall = 1'b1;
        stall_left--;
      end else begin
        mode_stall = 1'b0;
        stall_left = 0;
      end
    end
  end

  always @(posedge clk) begin
    mode_word_t exp_w;
    if (!rst && mode_valid && !mode_stall) begin
      if (pending_modes.size() == 0) begin
        report_mismatch($sformatf("unexpected mode word %h/%0d",
                                  mode_data.mode_symbol, mode_data.mode_count));
      end else begin
        exp_w = pending_modes.pop_front();
        if (mode_data.mode_symbol !== exp_w.mode_symbol)
          report_mismatch($sformatf("mode_symbol got %h exp %h",
                                    mode_data.mode_symbol, exp_w.mode_symbol));
        if (mode_data.mode_count !== exp_w.mode_count)
          report_mismatch($sformatf("mode_count got %0d exp %0d",
                                    mode_data.mode_count, exp_w.mode_count));
      end
    end
  end

  typedef struct {
    sym_t sym;
    bit   last;
    bit   typed;
    sym_t exp_sym;
    cnt_t exp_cnt;
  } dir_row_t;

  localparam int N_DIR = 20;
  dir_row_t dir_rows [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, 11'd1},  // single-byte texts, extremes
    '{8'hFF, 1'b1, 1'b1, 8'hFF, 11'd1},
    '{8'h5A, 1'b0, 1'b0, 8'h00, 11'd0},  // tie at one, earliest wins
    '{8'hA5, 1'b1, 1'b1, 8'h5A, 11'd1},
    '{8'h01, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h02, 1'b1, 1'b1, 8'h02, 11'd2},
    '{8'h80, 1'b0, 1'b0, 8'h00, 11'd0},  // late catch-up wins tie, earlier first appearance
    '{8'h7F, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h80, 1'b1, 1'b1, 8'h80, 11'd2},
    '{8'h3C, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'hC3, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h3C, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h3C, 1'b1, 1'b1, 8'h3C, 11'd3},
    '{8'h55, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'hAA, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'h55, 1'b0, 1'b0, 8'h00, 11'd0},
    '{8'hAA, 1'b1, 1'b0, 8'h00, 11'd0}
  };

  initial begin
    mode_word_t typed_w;
    mode_word_t none_w;
    sym_t       order [SYM_N];
    sym_t       pool  [8];
    sym_t       tmp, s;
    int         j, text_len, pool_n, rnd_items;
    none_w = '0;
    clear_tally();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      typed_w.mode_symbol = dir_rows[i].exp_sym;
      typed_w.mode_count  = dir_rows[i].exp_cnt;
      send_byte(dir_rows[i].sym, dir_rows[i].last, dir_rows[i].typed, typed_w);
    end

    // saturation: two values pass the ceiling, the first to appear keeps the lead
    for (int i = 0; i < 1030; i++) send_byte(8'h33, 1'b0, 1'b0, none_w);
    for (int i = 0; i < 1030; i++) send_byte(8'hC4, 1'b0, 1'b0, none_w);
    typed_w.mode_symbol = 8'h33;
    typed_w.mode_count  = MAX_CNT;
    send_byte(8'hC4, 1'b1, 1'b1, typed_w);

    // every value once in shuffled order, then some repeats: all ranks in use
    for (int i = 0; i < SYM_N; i++) order[i] = sym_t'(i);
    for (int i = SYM_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < SYM_N; i++) send_byte(order[i], 1'b0, 1'b0, none_w);
    for (int i = 0; i < 40; i++)
      send_byte(order[$urandom_range(200, 255)], i == 39, 1'b0, none_w);

    // random texts, mostly short, mostly from small alphabets so ties are common
    rnd_items = 0;
    while (rnd_items < 900) begin
      case ($urandom_range(0, 19))
        0:       text_len = $urandom_range(25, 160);
        1, 2:    text_len = 1;
        default: text_len = $urandom_range(2, 24);
      endcase
      pool_n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : 0;
      for (int k = 0; k < 8; k++) pool[k] = sym_t'($urandom);
      for (int k = 0; k < text_len; k++) begin
        s = (pool_n == 0) ? sym_t'($urandom) : pool[$urandom_range(0, pool_n - 1)];
        quiet = (rnd_items > 780);
        send_byte(s, k == text_len - 1, 1'b0, none_w);
        rnd_items++;
      end
    end

    sym_valid = 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_modes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
